// ===== sv/bmh_pkg.sv =====
// Shared types and constants for the binary min-heap priority queue.
// Used by the entry memory, the sequencer, the top level and the checker.
package bmh_pkg;

  localparam int KEY_W        = 32;
  localparam int HANDLE_W     = 16;
  localparam int COUNT_W      = 9;
  localparam int DEF_CAPACITY = 256;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_PEEK   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  typedef struct packed {
    status_t              status;
    entry_t               ent;
    logic [COUNT_W-1:0]   count;
  } res_t;

endpackage

// ===== sv/bmh_mem.sv =====
// Heap entry storage: one write port and two registered read ports.
// Depends on bmh_pkg for the entry type.
module bmh_mem
  import bmh_pkg::*;
#(
  parameter int DEPTH = DEF_CAPACITY + 1,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr0,
  input  logic [AW-1:0] raddr1,
  output entry_t        rdata0,
  output entry_t        rdata1
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// ===== sv/bmh_seq.sv =====
// Command sequencer with the single shared key comparator for sift-up and sift-down.
// Depends on bmh_pkg; drives the ports of bmh_mem.
module bmh_seq
  import bmh_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int AW       = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_command,
  input  logic [KEY_W-1:0]    in_key,
  input  logic [HANDLE_W-1:0] in_handle,
  output logic                busy,
  input  logic                res_take,
  output logic                res_valid,
  output res_t                res,
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output entry_t              mem_wdata,
  output logic [AW-1:0]       mem_raddr0,
  output logic [AW-1:0]       mem_raddr1,
  input  entry_t              mem_rdata0,
  input  entry_t              mem_rdata1
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_PK_LOAD,
    S_RM_LOAD,
    S_DN_SEL,
    S_DN_MOV,
    S_DONE
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] count_r, count_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [AW-1:0] sel_idx_r, sel_idx_nxt;
  entry_t        ent_r, ent_nxt;
  entry_t        sel_r, sel_nxt;
  res_t          res_r, res_nxt;

  logic [KEY_W-1:0] cmp_a;
  logic [KEY_W-1:0] cmp_b;
  logic             cmp_lt;

  logic [AW-1:0] ins_pos;
  logic [AW:0]   count_ext;
  logic [AW:0]   pos_x2;
  logic [AW:0]   pos_x2p1;
  logic [AW:0]   sel_x2;
  logic [AW:0]   sel_x2p1;
  logic          has_left;
  logic          has_right;

  assign ins_pos   = count_r + AW'(1);
  assign count_ext = {1'b0, count_r};
  assign pos_x2    = {pos_r, 1'b0};
  assign pos_x2p1  = {pos_r, 1'b1};
  assign sel_x2    = {sel_idx_r, 1'b0};
  assign sel_x2p1  = {sel_idx_r, 1'b1};
  assign has_left  = (pos_x2 <= count_ext);
  assign has_right = (pos_x2p1 <= count_ext);

  always_comb begin
    unique case (state_r)
      S_UP: begin
        cmp_a = ent_r.key;
        cmp_b = mem_rdata0.key;
      end
      S_DN_SEL: begin
        cmp_a = mem_rdata1.key;
        cmp_b = mem_rdata0.key;
      end
      S_DN_MOV: begin
        cmp_a = sel_r.key;
        cmp_b = ent_r.key;
      end
      default: begin
        cmp_a = ent_r.key;
        cmp_b = mem_rdata0.key;
      end
    endcase
  end

  assign cmp_lt = (cmp_a < cmp_b);

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    pos_nxt     = pos_r;
    sel_idx_nxt = sel_idx_r;
    ent_nxt     = ent_r;
    sel_nxt     = sel_r;
    res_nxt     = res_r;
    mem_we      = 1'b0;
    mem_waddr   = pos_r;
    mem_wdata   = ent_r;
    mem_raddr0  = pos_r >> 1;
    mem_raddr1  = pos_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_nxt.status = ST_OK;
          res_nxt.ent    = '0;
          unique case (cmd_t'(in_command))
            CMD_INSERT: begin
              if (count_r == AW'(CAPACITY)) begin
                res_nxt.status = ST_FULL;
                res_nxt.count  = COUNT_W'(count_r);
                state_nxt      = S_DONE;
              end else begin
                pos_nxt        = ins_pos;
                count_nxt      = ins_pos;
                ent_nxt        = '{key: in_key, handle: in_handle};
                res_nxt.count  = COUNT_W'(ins_pos);
                mem_raddr0     = ins_pos >> 1;
                state_nxt      = S_UP;
              end
            end
            CMD_REMOVE: begin
              if (count_r == '0) begin
                res_nxt.status = ST_EMPTY;
                res_nxt.count  = '0;
                state_nxt      = S_DONE;
              end else begin
                mem_raddr0     = AW'(1);
                mem_raddr1     = count_r;
                count_nxt      = count_r - AW'(1);
                res_nxt.count  = COUNT_W'(count_r - AW'(1));
                state_nxt      = S_RM_LOAD;
              end
            end
            CMD_PEEK: begin
              res_nxt.count = COUNT_W'(count_r);
              if (count_r == '0) begin
                res_nxt.status = ST_EMPTY;
                state_nxt      = S_DONE;
              end else begin
                mem_raddr0     = AW'(1);
                state_nxt      = S_PK_LOAD;
              end
            end
            CMD_CLEAR: begin
              count_nxt     = '0;
              res_nxt.count = '0;
              state_nxt     = S_DONE;
            end
          endcase
        end
      end
      S_UP: begin
        mem_we = 1'b1;
        if (pos_r == AW'(1) || !cmp_lt) begin
          mem_wdata = ent_r;
          state_nxt = S_DONE;
        end else begin
          mem_wdata  = mem_rdata0;
          pos_nxt    = pos_r >> 1;
          mem_raddr0 = pos_r >> 2;
        end
      end
      S_PK_LOAD: begin
        res_nxt.ent = mem_rdata0;
        state_nxt   = S_DONE;
      end
      S_RM_LOAD: begin
        res_nxt.ent = mem_rdata0;
        ent_nxt     = mem_rdata1;
        pos_nxt     = AW'(1);
        mem_raddr0  = AW'(2);
        mem_raddr1  = AW'(3);
        if (count_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DN_SEL;
        end
      end
      S_DN_SEL: begin
        if (!has_left) begin
          mem_we    = 1'b1;
          mem_wdata = ent_r;
          state_nxt = S_DONE;
        end else begin
          if (has_right && cmp_lt) begin
            sel_nxt     = mem_rdata1;
            sel_idx_nxt = pos_x2p1[AW-1:0];
          end else begin
            sel_nxt     = mem_rdata0;
            sel_idx_nxt = pos_x2[AW-1:0];
          end
          state_nxt = S_DN_MOV;
        end
      end
      S_DN_MOV: begin
        mem_we = 1'b1;
        if (cmp_lt) begin
          mem_wdata  = sel_r;
          pos_nxt    = sel_idx_r;
          mem_raddr0 = sel_x2[AW-1:0];
          mem_raddr1 = sel_x2p1[AW-1:0];
          state_nxt  = S_DN_SEL;
        end else begin
          mem_wdata = ent_r;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    pos_r     <= pos_nxt;
    sel_idx_r <= sel_idx_nxt;
    ent_r     <= ent_nxt;
    sel_r     <= sel_nxt;
    res_r     <= res_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

endmodule

// ===== sv/binary_min_heap_priority_queue.sv =====
// One command at a time: the input is stalled until the result word has moved into the output
// register, which waits while out_stall holds the previous word there. Sift-up takes the state
// S_UP per level and sift-down the states S_DN_SEL and S_DN_MOV per level, both set by the
// single key comparator and the registered reads of the entry memory.
// The input is stalled while reset is held.
// Reset clears the entry count and the control state; entry storage is not cleared.
module binary_min_heap_priority_queue
  import bmh_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_command,
  input  logic [KEY_W-1:0]    in_key,
  input  logic [HANDLE_W-1:0] in_handle,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic [KEY_W-1:0]    out_key,
  output logic [HANDLE_W-1:0] out_handle,
  output logic [COUNT_W-1:0]  out_entry_count
);

  localparam int DEPTH = CAPACITY + 1;
  localparam int AW    = $clog2(DEPTH);

  logic          busy;
  logic          res_valid;
  logic          res_take;
  res_t          res;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [AW-1:0] mem_raddr0;
  logic [AW-1:0] mem_raddr1;
  entry_t        mem_rdata0;
  entry_t        mem_rdata1;

  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;

  bmh_seq #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_key     (in_key),
    .in_handle  (in_handle),
    .busy       (busy),
    .res_take   (res_take),
    .res_valid  (res_valid),
    .res        (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr0 (mem_raddr0),
    .mem_raddr1 (mem_raddr1),
    .mem_rdata0 (mem_rdata0),
    .mem_rdata1 (mem_rdata1)
  );

  bmh_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (mem_wdata),
    .raddr0 (mem_raddr0),
    .raddr1 (mem_raddr1),
    .rdata0 (mem_rdata0),
    .rdata1 (mem_rdata1)
  );

  assign res_take = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res_valid && res_take) begin
      out_res_r <= res;
    end
  end

  assign in_stall        = busy || !rst_n;
  assign out_valid       = out_valid_r;
  assign out_status      = out_res_r.status;
  assign out_key         = out_res_r.ent.key;
  assign out_handle      = out_res_r.ent.handle;
  assign out_entry_count = out_res_r.count;

endmodule

// ===== sv/bmh_chk.sv =====
// Port-level checker for the binary min-heap priority queue, bound to the top level.
// Depends on bmh_pkg for status codes and field widths.
module bmh_chk
  import bmh_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [1:0]          out_status,
  input logic [KEY_W-1:0]    out_key,
  input logic [HANDLE_W-1:0] out_handle,
  input logic [COUNT_W-1:0]  out_entry_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_key)
      && $stable(out_handle) && $stable(out_entry_count))
    else $error("Stalled result word changed.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("Input not stalled while a command is in progress.");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |->
      out_entry_count == '0 && out_key == '0 && out_handle == '0)
    else $error("Empty status with a nonzero entry count or payload.");

  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |->
      out_entry_count == COUNT_W'(CAPACITY) && out_key == '0 && out_handle == '0)
    else $error("Full status without a full heap.");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_OK || out_status == ST_EMPTY || out_status == ST_FULL)
    else $error("Undefined status code.");

endmodule

bind binary_min_heap_priority_queue bmh_chk #(.CAPACITY(CAPACITY)) u_bmh_chk (.*);
